[design/fss_pkg.sv]
// Shared types, constants and byte helpers for the fuzzy subsequence scorer.
// Used by every module of the block; depends on nothing.
package fss_pkg;

  // Query storage and field widths
  localparam int QUERY_MAX   = 32;
  localparam int QLEN_W      = 6;
  localparam int POS_W       = 16;
  localparam int LAST_W      = POS_W + 2;
  localparam int SCORE_W     = 19;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int BYTES_PER_REG = 8;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_QUERY_LENGTH  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_QUERY_BYTES_0 = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_QUERY_BYTES_1 = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_QUERY_BYTES_2 = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_QUERY_BYTES_3 = 3'd4;

  // Result word kinds
  localparam logic KIND_RANGE = 1'b0;
  localparam logic KIND_SCORE = 1'b1;

  // Score terms
  localparam logic signed [SCORE_W-1:0] SC_MATCH    = 19'sd16;
  localparam logic signed [SCORE_W-1:0] SC_EXACT    = 19'sd2;
  localparam logic signed [SCORE_W-1:0] SC_BOUNDARY = 19'sd8;
  localparam logic signed [SCORE_W-1:0] SC_CONTIG   = 19'sd12;
  localparam logic signed [SCORE_W-1:0] SC_NONE     = -19'sd1;
  localparam logic [LAST_W-1:0]         LAST_RESET  = LAST_W'(-2); // minus two

  // Separator bytes
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Classified input word, front to back
  typedef struct packed {
    logic [7:0]       cbyte;
    logic [POS_W:0]   pos;     // position before this byte, saturates at 2^POS_W
    logic             bnd;     // word boundary at this byte
    logic             is_byte; // clear for an empty-candidate word
    logic             done;    // word closes the candidate
    logic [POS_W-1:0] len;     // saturated candidate length after this word
  } fss_word_t;

  // Result word
  typedef struct packed {
    logic                      kind;
    logic [POS_W-1:0]          rstart;
    logic [POS_W:0]            rend;
    logic                      matched;
    logic signed [SCORE_W-1:0] score;
    logic                      last;
  } fss_res_t;

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    return is_upper(c) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_SLASH) || (c == CH_BSLASH) || (c == CH_UNDER) ||
           (c == CH_DASH) || (c == CH_DOT) || (c == CH_SPACE);
  endfunction

endpackage

[design/fss_front.sv]
// Front end: accepts candidate bytes, tracks position and previous byte,
// and classifies each word for the back end. Depends on fss_pkg.
module fss_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              q_full_i,
  input  logic [7:0]        cand_byte_i,
  input  logic              end_of_candidate_i,
  input  logic              empty_candidate_i,
  output logic              q_push_o,
  output fss_pkg::fss_word_t word_o
);
  import fss_pkg::*;

  logic [POS_W:0] pos_q, pos_d, pos_inc;
  logic [7:0]     prev_q, prev_d;
  logic           acc;

  assign acc      = push_i && !q_full_i;
  assign q_push_o = acc;

  // Saturating position step
  assign pos_inc = pos_q[POS_W] ? pos_q : pos_q + 1'b1;

  // Classify the incoming word
  always_comb begin
    word_o.cbyte   = cand_byte_i;
    word_o.pos     = pos_q;
    word_o.bnd     = (pos_q == '0) || is_sep(prev_q) ||
                     (is_lower(prev_q) && is_upper(cand_byte_i));
    word_o.is_byte = !empty_candidate_i;
    word_o.done    = empty_candidate_i || end_of_candidate_i;
    if (empty_candidate_i) begin
      word_o.len = pos_q[POS_W] ? {POS_W{1'b1}} : pos_q[POS_W-1:0];
    end else begin
      word_o.len = pos_inc[POS_W] ? {POS_W{1'b1}} : pos_inc[POS_W-1:0];
    end
  end

  // Advance position, clear at candidate end
  always_comb begin
    pos_d  = pos_q;
    prev_d = prev_q;
    if (acc) begin
      if (word_o.done) begin
        pos_d  = '0;
        prev_d = '0;
      end else begin
        pos_d  = pos_inc;
        prev_d = cand_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      prev_q <= '0;
    end else begin
      pos_q  <= pos_d;
      prev_q <= prev_d;
    end
  end

endmodule

[design/fss_queue.sv]
// Four-entry word queue between front and back end.
// Depends on fss_pkg.
module fss_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  fss_pkg::fss_word_t wdata_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output fss_pkg::fss_word_t rdata_o
);
  import fss_pkg::*;

  fss_word_t  mem_q [4];
  logic [1:0] wp_q, wp_d, rp_q, rp_d;
  logic [2:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 3'd4);
  assign empty_o = (cnt_q == 3'd0);
  assign rdata_o = mem_q[rp_q];

  // Advance pointers and count
  always_comb begin
    wp_d  = wp_q + {1'b0, push_i};
    rp_d  = rp_q + {1'b0, pop_i};
    cnt_d = cnt_q + {2'b0, push_i} - {2'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

endmodule

[design/fss_back.sv]
// Back end: holds the query registers, matches words against the query,
// keeps the running score and emits range and score results. Depends on fss_pkg.
module fss_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fss_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [fss_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                q_empty_i,
  input  fss_pkg::fss_word_t                  word_i,
  output logic                                q_pop_o,
  input  logic                                room_i,
  output logic [2:0]                          res_vld_o,
  output fss_pkg::fss_res_t                   res_o [3]
);
  import fss_pkg::*;

  // Query registers
  logic [QLEN_W-1:0]          qlen_q;
  logic [QUERY_MAX-1:0][7:0]  qbytes_q;

  // Candidate state
  logic [QLEN_W-1:0]          qi_q, qi_d;
  logic signed [SCORE_W-1:0]  acc_q, acc_d;
  logic [LAST_W-1:0]          last_q, last_d;
  logic [POS_W-1:0]           first_q, first_d;
  logic [POS_W-1:0]           rstart_q, rstart_d;
  logic                       run_q, run_d;

  logic                       fire, hit, contig, exact, done, close_old, close_fin;
  logic [QLEN_W-1:0]          qlen;
  logic [7:0]                 qbyte;
  logic [LAST_W-1:0]          pos18, lastp1, gap, last_nx_p1;
  logic signed [SCORE_W-1:0]  base, delta, acc_nx;
  logic [QLEN_W-1:0]          qi_nx;
  logic [LAST_W-1:0]          last_nx;
  logic [POS_W-1:0]           first_nx, rstart_nx;
  logic                       run_nx;
  logic [POS_W-1:0]           diff;
  logic [POS_W:0]             pen;
  logic signed [SCORE_W:0]    sc_wide;
  logic signed [SCORE_W-1:0]  sc_sat, sc_out;
  logic                       m_out;

  // Write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qlen_q   <= '0;
      qbytes_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_QUERY_LENGTH:  qlen_q <= cfg_wdata_i[QLEN_W-1:0];
        REG_QUERY_BYTES_0: qbytes_q[0*BYTES_PER_REG +: BYTES_PER_REG] <= cfg_wdata_i;
        REG_QUERY_BYTES_1: qbytes_q[1*BYTES_PER_REG +: BYTES_PER_REG] <= cfg_wdata_i;
        REG_QUERY_BYTES_2: qbytes_q[2*BYTES_PER_REG +: BYTES_PER_REG] <= cfg_wdata_i;
        REG_QUERY_BYTES_3: qbytes_q[3*BYTES_PER_REG +: BYTES_PER_REG] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign fire    = !q_empty_i && room_i;
  assign q_pop_o = fire;
  assign qlen    = (qlen_q > QLEN_W'(QUERY_MAX)) ? QLEN_W'(QUERY_MAX) : qlen_q;
  assign qbyte   = qbytes_q[qi_q[4:0]];
  assign exact   = (qbyte == word_i.cbyte);

  // Match the word against the current query byte
  always_comb begin
    hit    = fire && word_i.is_byte && !word_i.pos[POS_W] && (qi_q < qlen) &&
             (fold(qbyte) == fold(word_i.cbyte));
    pos18  = {1'b0, word_i.pos};
    lastp1 = last_q + LAST_W'(1);
    contig = (pos18 == lastp1);
    gap    = pos18 - lastp1;
    base   = SC_MATCH + (exact ? SC_EXACT : '0) + (word_i.bnd ? SC_BOUNDARY : '0);
    delta  = contig ? base + SC_CONTIG : base - $signed({1'b0, gap});
    acc_nx = hit ? acc_q + delta : acc_q;
    qi_nx  = hit ? qi_q + 1'b1 : qi_q;
    last_nx  = hit ? pos18 : last_q;
    first_nx = (hit && (qi_q == '0)) ? word_i.pos[POS_W-1:0] : first_q;
    close_old = hit && run_q && !contig;
    rstart_nx = (hit && !(run_q && contig)) ? word_i.pos[POS_W-1:0] : rstart_q;
    run_nx    = run_q || hit;
    done      = fire && word_i.done;
    close_fin = done && run_nx;
    last_nx_p1 = last_nx + LAST_W'(1);
  end

  // Work out the final score
  always_comb begin
    diff    = (word_i.len > {{(POS_W-QLEN_W){1'b0}}, qlen}) ?
              word_i.len - {{(POS_W-QLEN_W){1'b0}}, qlen} : '0;
    pen     = {3'b0, diff[POS_W-1:2]} + {1'b0, first_nx};
    sc_wide = {acc_nx[SCORE_W-1], acc_nx} - $signed({{(SCORE_W-POS_W){1'b0}}, pen});
    if (sc_wide[SCORE_W] != sc_wide[SCORE_W-1]) begin
      sc_sat = sc_wide[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
    end else begin
      sc_sat = sc_wide[SCORE_W-1:0];
    end
    if (qlen == '0) begin
      m_out  = 1'b1;
      sc_out = '0;
    end else if (qi_nx == qlen) begin
      m_out  = 1'b1;
      sc_out = sc_sat;
    end else begin
      m_out  = 1'b0;
      sc_out = SC_NONE;
    end
  end

  // Build the result words
  always_comb begin
    res_o[0]         = '0;
    res_o[0].kind    = KIND_RANGE;
    res_o[0].rstart  = rstart_q;
    res_o[0].rend    = lastp1[POS_W:0];
    res_o[1]         = '0;
    res_o[1].kind    = KIND_RANGE;
    res_o[1].rstart  = rstart_nx;
    res_o[1].rend    = last_nx_p1[POS_W:0];
    res_o[2]         = '0;
    res_o[2].kind    = KIND_SCORE;
    res_o[2].matched = m_out;
    res_o[2].score   = sc_out;
    res_o[2].last    = 1'b1;
    res_vld_o        = {done, close_fin, close_old};
  end

  // Hold, advance or clear candidate state
  always_comb begin
    qi_d     = qi_q;
    acc_d    = acc_q;
    last_d   = last_q;
    first_d  = first_q;
    rstart_d = rstart_q;
    run_d    = run_q;
    if (done) begin
      qi_d     = '0;
      acc_d    = '0;
      last_d   = LAST_RESET;
      first_d  = '0;
      rstart_d = '0;
      run_d    = 1'b0;
    end else if (fire) begin
      qi_d     = qi_nx;
      acc_d    = acc_nx;
      last_d   = last_nx;
      first_d  = first_nx;
      rstart_d = rstart_nx;
      run_d    = run_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qi_q     <= '0;
      acc_q    <= '0;
      last_q   <= LAST_RESET;
      first_q  <= '0;
      rstart_q <= '0;
      run_q    <= 1'b0;
    end else begin
      qi_q     <= qi_d;
      acc_q    <= acc_d;
      last_q   <= last_d;
      first_q  <= first_d;
      rstart_q <= rstart_d;
      run_q    <= run_d;
    end
  end

endmodule

[design/fss_outq.sv]
// Eight-entry result queue that takes up to three words per cycle in order.
// Depends on fss_pkg.
module fss_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [2:0]        wr_vld_i,
  input  fss_pkg::fss_res_t wr_data_i [3],
  output logic              room_o,
  input  logic              pop_i,
  output logic              empty_o,
  output fss_pkg::fss_res_t rd_data_o
);
  import fss_pkg::*;

  fss_res_t   mem_q [8];
  logic [2:0] wp_q, wp_d, rp_q, rp_d;
  logic [3:0] cnt_q, cnt_d;
  logic [1:0] nwr;
  logic [1:0] off [3];
  logic       do_pop;

  assign empty_o   = (cnt_q == 4'd0);
  assign room_o    = (cnt_q <= 4'd5);
  assign rd_data_o = mem_q[rp_q];
  assign do_pop    = pop_i && !empty_o;

  // Pack valid words into consecutive slots
  always_comb begin
    off[0] = 2'd0;
    off[1] = {1'b0, wr_vld_i[0]};
    off[2] = {1'b0, wr_vld_i[0]} + {1'b0, wr_vld_i[1]};
    nwr    = off[2] + {1'b0, wr_vld_i[2]};
    wp_d   = wp_q + {1'b0, nwr};
    rp_d   = rp_q + {2'b0, do_pop};
    cnt_d  = cnt_q + {2'b0, nwr} - {3'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the words
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      if (wr_vld_i[j]) begin
        mem_q[wp_q + {1'b0, off[j]}] <= wr_data_i[j];
      end
    end
  end

endmodule

[design/fuzzy_subsequence_scorer.sv]
// Fuzzy subsequence scorer: front classifier, word queue, scoring back end,
// result queue. Takes one candidate byte per cycle while the word queue is not full;
// depends on fss_pkg. A byte is registered in the word queue; once the back end takes it,
// its results are written to the result queue, from whose head they are popped.
// Throughput: one byte per cycle, through a combinational match and score step;
// the back end waits only when the result queue has fewer than three free slots.
// Reset: all queues empty, query length zero, query bytes zero, candidate cleared.
module fuzzy_subsequence_scorer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  logic [7:0]                           cand_byte_i,
  input  logic                                 end_of_candidate_i,
  input  logic                                 empty_candidate_i,
  input  logic                                 cfg_we_i,
  input  logic [fss_pkg::CFG_ADDR_W-1:0]       cfg_addr_i,
  input  logic [fss_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic                                 item_kind_o,
  output logic [fss_pkg::POS_W-1:0]            range_start_o,
  output logic [fss_pkg::POS_W:0]              range_end_o,
  output logic                                 matched_o,
  output logic signed [fss_pkg::SCORE_W-1:0]   score_o,
  output logic                                 last_of_run_o
);
  import fss_pkg::*;

  fss_word_t  f_word, b_word;
  logic       f_push, q_full, q_empty, b_pop, room;
  logic [2:0] res_vld;
  fss_res_t   res [3];
  fss_res_t   head;

  fss_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push_i             (push),
    .q_full_i           (q_full),
    .cand_byte_i        (cand_byte_i),
    .end_of_candidate_i (end_of_candidate_i),
    .empty_candidate_i  (empty_candidate_i),
    .q_push_o           (f_push),
    .word_o             (f_word)
  );

  fss_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .wdata_i (f_word),
    .full_o  (q_full),
    .pop_i   (b_pop),
    .empty_o (q_empty),
    .rdata_o (b_word)
  );

  fss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_empty_i   (q_empty),
    .word_i      (b_word),
    .q_pop_o     (b_pop),
    .room_i      (room),
    .res_vld_o   (res_vld),
    .res_o       (res)
  );

  fss_outq u_outq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_vld_i  (res_vld),
    .wr_data_i (res),
    .room_o    (room),
    .pop_i     (pop),
    .empty_o   (empty),
    .rd_data_o (head)
  );

  // Drive the result ports from the queue head
  assign full          = q_full;
  assign item_kind_o   = head.kind;
  assign range_start_o = head.rstart;
  assign range_end_o   = head.rend;
  assign matched_o     = head.matched;
  assign score_o       = head.score;
  assign last_of_run_o = head.last;

endmodule

[tb/testbench.sv]
// Self-checking testbench for the fuzzy subsequence scorer: directed and random candidates,
// each result word checked against a behavioral scorer kept in this file.
// Depends on fss_pkg and the fuzzy_subsequence_scorer top level.
module testbench;
  import fss_pkg::*;

  localparam int     POS_LIMIT = (1 << POS_W) - 1;
  localparam longint SCORE_HI  = (longint'(1) << (SCORE_W - 1)) - 1;
  localparam longint SCORE_LO  = -SCORE_HI - 1;
  localparam int     PHASE_BYTES = 24;

  // One candidate word as it goes to the block
  typedef struct packed {
    logic [7:0] cbyte;
    logic       eoc;
    logic       ecand;
  } cand_word_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        push = 1'b0;
  logic                        full;
  logic [7:0]                  cand_byte_i = '0;
  logic                        end_of_candidate_i = 1'b0;
  logic                        empty_candidate_i = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0]       cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0]       cfg_wdata_i = '0;
  logic                        empty;
  logic                        pop = 1'b0;
  logic                        item_kind_o;
  logic [POS_W-1:0]            range_start_o;
  logic [POS_W:0]              range_end_o;
  logic                        matched_o;
  logic signed [SCORE_W-1:0]   score_o;
  logic                        last_of_run_o;

  fuzzy_subsequence_scorer u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .cand_byte_i        (cand_byte_i),
    .end_of_candidate_i (end_of_candidate_i),
    .empty_candidate_i  (empty_candidate_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_addr_i         (cfg_addr_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .empty              (empty),
    .pop                (pop),
    .item_kind_o        (item_kind_o),
    .range_start_o      (range_start_o),
    .range_end_o        (range_end_o),
    .matched_o          (matched_o),
    .score_o            (score_o),
    .last_of_run_o      (last_of_run_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Stimulus and expected result stores
  cand_word_t byte_queue [$];
  fss_res_t   results_due [$];

  // Scorer copy of the query registers
  logic [QLEN_W-1:0] q_len = '0;
  logic [63:0]       q_words [4];

  // Scorer copy of the candidate state
  int         m_idx;
  longint     acc;
  longint     last_pos;
  longint     first_pos;
  longint     cand_pos;
  longint     run_beg;
  logic [7:0] prev_byte;
  bit         run_on;

  // Traffic control and bookkeeping
  bit         tx_gaps = 1'b1;
  bit         rx_stalls = 1'b1;
  bit         tx_paused = 1'b0;
  int         gap_left = 0;
  int         stall_left = 0;
  int         err_count = 0;
  int         words_sent = 0;
  int         n_ranges = 0;
  int         n_scores = 0;
  int         n_matched = 0;
  cand_word_t next_word;
  fss_res_t   seen_res;
  fss_res_t   due_res;

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 50) $display("MISMATCH: %s", msg);
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] fold_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] swap_case(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return c + 8'd32;
    if (c >= "a" && c <= "z") return c - 8'd32;
    return c;
  endfunction

  function automatic bit word_break(input logic [7:0] c);
    return c == "/" || c == "\\" || c == "_" || c == "-" || c == "." || c == " ";
  endfunction

  function automatic logic [7:0] sep_byte();
    case ($urandom_range(0, 5))
      0: return "/";
      1: return "\\";
      2: return "_";
      3: return "-";
      4: return ".";
      default: return " ";
    endcase
  endfunction

  function automatic logic [7:0] any_byte();
    logic [7:0] b;
    b = 8'($urandom);
    return b;
  endfunction

  function automatic logic [7:0] filler();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return sep_byte();
    if (r < 5) return 8'("a" + $urandom_range(0, 25));
    if (r < 7) return 8'("A" + $urandom_range(0, 25));
    return any_byte();
  endfunction

  // Small alphabet so that random candidates still hit the query
  function automatic logic [7:0] query_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 8'("a" + $urandom_range(0, 7));
    if (r < 8) return 8'("A" + $urandom_range(0, 7));
    if (r < 9) return sep_byte();
    return any_byte();
  endfunction

  task automatic clear_match();
    m_idx     = 0;
    acc       = 0;
    last_pos  = -2;
    first_pos = 0;
    cand_pos  = 0;
    prev_byte = '0;
    run_beg   = 0;
    run_on    = 1'b0;
  endtask

  task automatic expect_range(input longint s, input longint e);
    fss_res_t r;
    r        = '0;
    r.kind   = KIND_RANGE;
    r.rstart = s[POS_W-1:0];
    r.rend   = e[POS_W:0];
    results_due.insert(results_due.size(), r);
  endtask

  // Advance the scorer by one accepted word and queue the words it yields
  task automatic score_byte(input cand_word_t w);
    int         qn;
    logic [7:0] qb;
    bit         closes;
    bit         contig;
    longint     p;
    longint     len;
    longint     diff;
    longint     sc;
    fss_res_t   r;
    qn = (q_len > QUERY_MAX) ? QUERY_MAX : int'(q_len);
    closes = 1'b1;
    if (!w.ecand) begin
      p = cand_pos;
      if (p <= POS_LIMIT && m_idx < qn) begin
        qb = q_words[m_idx / 8][(m_idx % 8) * 8 +: 8];
        if (fold_letter(qb) == fold_letter(w.cbyte)) begin
          contig = (p == last_pos + 1);
          acc += 16;
          if (qb == w.cbyte) acc += 2;
          if (p == 0 || word_break(prev_byte) ||
              (prev_byte >= "a" && prev_byte <= "z" && w.cbyte >= "A" && w.cbyte <= "Z"))
            acc += 8;
          if (contig) acc += 12;
          else acc -= p - last_pos - 1;
          // Close the previous run unless this byte extends it
          if (!(run_on && contig)) begin
            if (run_on) expect_range(run_beg, last_pos + 1);
            run_beg = p;
            run_on  = 1'b1;
          end
          if (m_idx == 0) first_pos = p;
          last_pos = p;
          m_idx++;
        end
      end
      prev_byte = w.cbyte;
      if (cand_pos <= POS_LIMIT) cand_pos++;
      closes = w.eoc;
    end
    if (closes) begin
      if (run_on) expect_range(run_beg, last_pos + 1);
      r      = '0;
      r.kind = KIND_SCORE;
      r.last = 1'b1;
      if (qn == 0) begin
        r.matched = 1'b1;
        r.score   = '0;
      end else if (m_idx == qn) begin
        len  = (cand_pos > POS_LIMIT) ? POS_LIMIT : cand_pos;
        diff = len - qn;
        if (diff < 0) diff = 0;
        sc = acc - diff / 4 - first_pos;
        if (sc < SCORE_LO) sc = SCORE_LO;
        if (sc > SCORE_HI) sc = SCORE_HI;
        r.matched = 1'b1;
        r.score   = sc[SCORE_W-1:0];
      end else begin
        r.matched = 1'b0;
        r.score   = SC_NONE;
      end
      results_due.insert(results_due.size(), r);
      clear_match();
    end
  endtask

  // Driver: feed words from the queue, hold on full, insert gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
      gap_left = 0;
    end else begin
      if (push && !full) begin
        score_byte({cand_byte_i, end_of_candidate_i, empty_candidate_i});
        words_sent++;
        if (tx_gaps) gap_left = pick_gap();
      end
      if (tx_paused && results_due.size() == 0) tx_paused = 1'b0;
      if (!(push && full)) begin
        if (gap_left > 0) begin
          push <= 1'b0;
          gap_left--;
        end else if (byte_queue.size() != 0 && !tx_paused) begin
          next_word = byte_queue.pop_front();
          cand_byte_i        <= next_word.cbyte;
          end_of_candidate_i <= next_word.eoc;
          empty_candidate_i  <= next_word.ecand;
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each popped word against the oldest expectation, stall at random
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
      stall_left = 0;
    end else begin
      if (pop && !empty) begin
        seen_res.kind    = item_kind_o;
        seen_res.rstart  = range_start_o;
        seen_res.rend    = range_end_o;
        seen_res.matched = matched_o;
        seen_res.score   = score_o;
        seen_res.last    = last_of_run_o;
        if (seen_res.kind === KIND_SCORE) begin
          n_scores++;
          if (seen_res.matched === 1'b1) n_matched++;
        end else begin
          n_ranges++;
        end
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result word, kind %0d score %0d",
                                    seen_res.kind, seen_res.score));
        end else begin
          due_res = results_due.pop_front();
          if (seen_res.kind !== due_res.kind || seen_res.rstart !== due_res.rstart ||
              seen_res.rend !== due_res.rend || seen_res.matched !== due_res.matched ||
              seen_res.score !== due_res.score || seen_res.last !== due_res.last)
            report_mismatch($sformatf(
              "got kind %0d range %0d..%0d matched %0d score %0d last %0d, want %0d %0d..%0d %0d %0d %0d",
              seen_res.kind, seen_res.rstart, seen_res.rend, seen_res.matched,
              seen_res.score, seen_res.last, due_res.kind, due_res.rstart, due_res.rend,
              due_res.matched, due_res.score, due_res.last));
        end
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        if (rx_stalls && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_QUERY_LENGTH:  q_len = val[QLEN_W-1:0];
      REG_QUERY_BYTES_0: q_words[0] = val;
      REG_QUERY_BYTES_1: q_words[1] = val;
      REG_QUERY_BYTES_2: q_words[2] = val;
      REG_QUERY_BYTES_3: q_words[3] = val;
      default: ;
    endcase
  endtask

  task automatic load_query(input int len, input logic [63:0] w0, input logic [63:0] w1,
                            input logic [63:0] w2, input logic [63:0] w3);
    write_reg(REG_QUERY_LENGTH, CFG_DATA_W'(len));
    write_reg(REG_QUERY_BYTES_0, w0);
    write_reg(REG_QUERY_BYTES_1, w1);
    write_reg(REG_QUERY_BYTES_2, w2);
    write_reg(REG_QUERY_BYTES_3, w3);
  endtask

  // Wait until every word is accepted and every result has come, then let the pipe settle
  task automatic drain();
    while (byte_queue.size() != 0 || push || results_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic queue_word(input logic [7:0] b, input logic eoc, input logic ecand);
    byte_queue.insert(byte_queue.size(), {b, eoc, ecand});
  endtask

  task automatic queue_text(input string s, input bit closes);
    int i;
    for (i = 0; i < s.len(); i++)
      queue_word(s[i], closes && (i == s.len() - 1), 1'b0);
  endtask

  // Build one candidate: mostly the query spread out with fillers, sometimes broken or random
  task automatic queue_candidate(input bit keep_open);
    cand_word_t cw [$];
    cand_word_t w;
    int         qn;
    int         style;
    int         i;
    logic [7:0] b;
    qn = (q_len > QUERY_MAX) ? QUERY_MAX : int'(q_len);
    style = $urandom_range(0, 19);
    if (style < 13) begin
      for (i = 0; i < qn; i++) begin
        if (style >= 11 && i == qn / 2) continue;
        repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 2))
          cw.insert(cw.size(), {filler(), 2'b00});
        b = q_words[i / 8][(i % 8) * 8 +: 8];
        if ($urandom_range(0, 4) < 2) b = swap_case(b);
        cw.insert(cw.size(), {b, 2'b00});
      end
      repeat ($urandom_range(0, 3)) cw.insert(cw.size(), {filler(), 2'b00});
    end else begin
      repeat ($urandom_range(0, 10)) cw.insert(cw.size(), {filler(), 2'b00});
    end
    if (keep_open) begin
      if (cw.size() == 0) cw.insert(cw.size(), {filler(), 2'b00});
    end else if (cw.size() == 0 || $urandom_range(0, 6) == 0) begin
      // close through the empty-candidate flag; byte and end flag are don't-care
      cw.insert(cw.size(), {any_byte(), 1'($urandom_range(0, 1)), 1'b1});
    end else begin
      w = cw.pop_back();
      w.eoc = 1'b1;
      cw.insert(cw.size(), w);
    end
    foreach (cw[j]) byte_queue.insert(byte_queue.size(), cw[j]);
  endtask

  initial begin : stimulus
    int          ph;
    int          qn;
    int          i;
    int          half;
    logic [63:0] qw [4];
    foreach (q_words[j]) q_words[j] = '0;
    clear_match();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Empty query after reset, extreme bytes, zero-length candidate
    queue_word(8'hFF, 1'b0, 1'b0);
    queue_word(8'h00, 1'b1, 1'b0);
    queue_word("x", 1'b1, 1'b1);
    drain();

    // Query "aBc": gaps, separator boundary, lower-to-upper boundary, exact case,
    // trailing bytes after a full match, empty flag closing a partial candidate
    load_query(3, 64'h0000_0000_0063_4261, '1, '0, {$urandom, $urandom});
    queue_text("za-Bxc", 1'b1);
    queue_text("aBcQ", 1'b1);
    queue_text("ab", 1'b0);
    queue_word("q", 1'b1, 1'b1);
    drain();

    // Query "abcdef": every separator ahead of a match
    load_query(6, 64'h0000_6665_6463_6261, '0, '0, '0);
    queue_text("/a\\b_c-d.e f", 1'b1);
    drain();

    // Random phases, each with its own query and traffic pattern
    for (ph = 0; ph < 8; ph++) begin
      tx_gaps   = ($urandom_range(0, 3) != 0);
      rx_stalls = ($urandom_range(0, 3) != 0);
      case (ph)
        0: qn = QUERY_MAX;
        1: qn = 63;
        2: qn = 0;
        3: qn = 1;
        default: qn = $urandom_range(1, 8);
      endcase
      for (i = 0; i < 32; i++) qw[i / 8][(i % 8) * 8 +: 8] = query_char();
      if (ph == 2 || ph == 3) foreach (qw[j]) qw[j] = '1;
      load_query(qn, qw[0], qw[1], qw[2], qw[3]);
      while (byte_queue.size() < PHASE_BYTES) queue_candidate(1'b0);
      // leave one candidate open across a register update
      if (ph == 5) queue_candidate(1'b1);
      // hold the sender mid-phase until the block has drained
      half = byte_queue.size() / 2;
      while (byte_queue.size() > half) @(posedge clk_i);
      tx_paused = 1'b1;
      drain();
    end

    $display("%0d candidate words sent, %0d range words and %0d score words checked (%0d matched)",
             words_sent, n_ranges, n_scores, n_matched);
    $display("queries: empty, single byte, oversized length, all 32 bytes; separators, case");
    $display("changes, empty-flag endings and a candidate left open across a query change");
    if (err_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // Hang guard
  initial begin
    #14_400_000;
    $display("simulation failed");
    $finish;
  end

endmodule
